/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the RTL of the gain search unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Check a property on every rising clk edge outside of reset.
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Check a property on every rising clk edge, reset included.
`define ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define ASSERT_CLK(label, prop)
`define ASSERT_ALWAYS(label, prop)
`endif

`endif

/* rtl/core/rgps_pkg.sv */
// ----------------------------------------------------------------------------
// rgps_pkg
// Types, widths and codes shared by the receiver gain / power search unit.
// ----------------------------------------------------------------------------
package rgps_pkg;

  // Channel table geometry
  localparam int CHANNELS  = 16;
  localparam int CH_W      = 4;
  localparam int ADDR_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int GAIN_STEP = 10;

  // Field widths
  localparam int LVL_W  = 13;
  localparam int TOL_W  = 10;
  localparam int GAIN_W = 7;
  localparam int STAT_W = 3;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LEVEL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_POWER    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_POWER    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAIN     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_GAIN     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_START_GAIN   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_START_POWER  = 3'd7;

  // Register reset values
  localparam logic signed [LVL_W-1:0] RST_TARGET_LEVEL = -13'sd960;
  localparam logic [TOL_W-1:0]        RST_TOLERANCE    = 10'd16;
  localparam logic signed [LVL_W-1:0] RST_MIN_POWER    = -13'sd1920;
  localparam logic signed [LVL_W-1:0] RST_MAX_POWER    = -13'sd400;
  localparam logic [GAIN_W-1:0]       RST_MIN_GAIN     = 7'd14;
  localparam logic [GAIN_W-1:0]       RST_MAX_GAIN     = 7'd108;
  localparam logic [GAIN_W-1:0]       RST_START_GAIN   = 7'd60;
  localparam logic signed [LVL_W-1:0] RST_START_POWER  = -13'sd800;

  // Item actions
  localparam logic ACT_INIT    = 1'b0;
  localparam logic ACT_MEASURE = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_ADJUSTING = 3'd0;
  localparam logic [STAT_W-1:0] STAT_CONVERGED = 3'd1;
  localparam logic [STAT_W-1:0] STAT_DONE      = 3'd2;
  localparam logic [STAT_W-1:0] STAT_GAIN_HIGH = 3'd3;
  localparam logic [STAT_W-1:0] STAT_GAIN_LOW  = 3'd4;

  typedef struct packed {
    logic signed [LVL_W-1:0] target_level;
    logic [TOL_W-1:0]        tolerance;
    logic signed [LVL_W-1:0] min_power;
    logic signed [LVL_W-1:0] max_power;
    logic [GAIN_W-1:0]       min_gain_index;
    logic [GAIN_W-1:0]       max_gain_index;
    logic [GAIN_W-1:0]       start_gain_index;
    logic signed [LVL_W-1:0] start_power;
  } rgps_cfg_t;

  // One write-back into the channel table
  typedef struct packed {
    logic                    en;
    logic [ADDR_W-1:0]       addr;
    logic signed [LVL_W-1:0] power;
    logic [GAIN_W-1:0]       gain;
    logic                    done;
  } rgps_wr_t;

  // Map a channel number onto a table address
  function automatic logic [ADDR_W-1:0] ch_addr(input logic [CH_W-1:0] ch);
    logic [ADDR_W+CH_W-1:0] ext;
    ext = {{ADDR_W{1'b0}}, ch};
    return ext[ADDR_W-1:0];
  endfunction

  // True when the channel number has an entry in the table
  function automatic logic ch_exists(input logic [CH_W-1:0] ch);
    return (int'(ch) < CHANNELS);
  endfunction

endpackage

/* rtl/core/rgps_cfg_regs.sv */
// ----------------------------------------------------------------------------
// rgps_cfg_regs
// Configuration register file, written through a plain indexed write port.
// ----------------------------------------------------------------------------
module rgps_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [rgps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rgps_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output rgps_pkg::rgps_cfg_t                 cfg
);

  rgps_pkg::rgps_cfg_t cfg_r, cfg_nxt;

  // Decode the write index
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        rgps_pkg::CFG_TARGET_LEVEL: cfg_nxt.target_level = $signed(cfg_wdata);
        rgps_pkg::CFG_TOLERANCE:    cfg_nxt.tolerance = cfg_wdata[rgps_pkg::TOL_W-1:0];
        rgps_pkg::CFG_MIN_POWER:    cfg_nxt.min_power = $signed(cfg_wdata);
        rgps_pkg::CFG_MAX_POWER:    cfg_nxt.max_power = $signed(cfg_wdata);
        rgps_pkg::CFG_MIN_GAIN:     cfg_nxt.min_gain_index = cfg_wdata[rgps_pkg::GAIN_W-1:0];
        rgps_pkg::CFG_MAX_GAIN:     cfg_nxt.max_gain_index = cfg_wdata[rgps_pkg::GAIN_W-1:0];
        rgps_pkg::CFG_START_GAIN:   cfg_nxt.start_gain_index =
                                      cfg_wdata[rgps_pkg::GAIN_W-1:0];
        rgps_pkg::CFG_START_POWER:  cfg_nxt.start_power = $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  // Hold the registers, load reset values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_level     <= rgps_pkg::RST_TARGET_LEVEL;
      cfg_r.tolerance        <= rgps_pkg::RST_TOLERANCE;
      cfg_r.min_power        <= rgps_pkg::RST_MIN_POWER;
      cfg_r.max_power        <= rgps_pkg::RST_MAX_POWER;
      cfg_r.min_gain_index   <= rgps_pkg::RST_MIN_GAIN;
      cfg_r.max_gain_index   <= rgps_pkg::RST_MAX_GAIN;
      cfg_r.start_gain_index <= rgps_pkg::RST_START_GAIN;
      cfg_r.start_power      <= rgps_pkg::RST_START_POWER;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/core/rgps_chan_mem.sv */
// ----------------------------------------------------------------------------
// rgps_chan_mem
// Per-channel state table: power and gain in a synchronous memory with a
// registered read, done marks in flops cleared by reset.
// ----------------------------------------------------------------------------
module rgps_chan_mem (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 rd_en,
  input  logic [rgps_pkg::ADDR_W-1:0]          rd_addr,
  input  rgps_pkg::rgps_wr_t                   wr,
  output logic signed [rgps_pkg::LVL_W-1:0]    rd_power,
  output logic [rgps_pkg::GAIN_W-1:0]          rd_gain,
  output logic                                 rd_done
);

  localparam int ENT_W = rgps_pkg::LVL_W + rgps_pkg::GAIN_W;

  logic [ENT_W-1:0]             mem [rgps_pkg::CHANNELS];
  logic [ENT_W-1:0]             rdata_r;
  logic [rgps_pkg::CHANNELS-1:0] done_r;
  logic                          rd_done_r;

  // Write and read the power/gain array
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= {wr.power, wr.gain};
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // Done marks, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r    <= '0;
      rd_done_r <= 1'b0;
    end else begin
      if (wr.en) begin
        done_r[wr.addr] <= wr.done;
      end
      if (rd_en) begin
        rd_done_r <= done_r[rd_addr];
      end
    end
  end

  assign rd_power = $signed(rdata_r[ENT_W-1:rgps_pkg::GAIN_W]);
  assign rd_gain  = rdata_r[rgps_pkg::GAIN_W-1:0];
  assign rd_done  = rd_done_r;

endmodule

/* rtl/core/rgps_step.sv */
// ----------------------------------------------------------------------------
// rgps_step
// One search step: window compare, power correction with clamp, gain step
// with clamp and power midpoint, and the result status.
// ----------------------------------------------------------------------------
module rgps_step (
  input  rgps_pkg::rgps_cfg_t                  cfg,
  input  logic                                 action,
  input  logic                                 ch_ok,
  input  logic signed [rgps_pkg::LVL_W-1:0]    rssi,
  input  logic signed [rgps_pkg::LVL_W-1:0]    cur_power,
  input  logic [rgps_pkg::GAIN_W-1:0]          cur_gain,
  input  logic                                 cur_done,
  output logic signed [rgps_pkg::LVL_W-1:0]    res_power,
  output logic [rgps_pkg::GAIN_W-1:0]          res_gain,
  output logic [rgps_pkg::STAT_W-1:0]          res_status,
  output logic                                 wr_en,
  output logic                                 wr_done
);

  localparam int W1 = rgps_pkg::LVL_W + 1;
  localparam int W2 = rgps_pkg::LVL_W + 2;
  localparam int GW = rgps_pkg::GAIN_W + 2;

  logic signed [W1-1:0] lo_t, hi_t, err, lim_sum, rssi_x;
  logic signed [W2-1:0] stepped, pw_clamp;
  logic signed [rgps_pkg::LVL_W-1:0] mid, pw_new;
  logic signed [GW-1:0] g_up, g_dn, g_sel, g_clamp, g_min, g_max;
  logic [rgps_pkg::GAIN_W-1:0] gn_new;
  logic in_win, too_high;

  // Window bounds, error and midpoint
  always_comb begin
    rssi_x   = W1'(rssi);
    lo_t     = W1'(cfg.target_level) - $signed({4'b0, cfg.tolerance});
    hi_t     = W1'(cfg.target_level) + $signed({4'b0, cfg.tolerance});
    err      = rssi_x - W1'(cfg.target_level);
    lim_sum  = W1'(cfg.min_power) + W1'(cfg.max_power);
    mid      = rgps_pkg::LVL_W'(lim_sum >>> 1);
    in_win   = (rssi_x >= lo_t) && (rssi_x <= hi_t);
    too_high = (rssi_x > hi_t);
  end

  // Corrected power, clamped high first then low
  always_comb begin
    stepped  = W2'(cur_power) - W2'(err);
    pw_clamp = stepped;
    if (pw_clamp > W2'(cfg.max_power)) begin
      pw_clamp = W2'(cfg.max_power);
    end
    if (pw_clamp < W2'(cfg.min_power)) begin
      pw_clamp = W2'(cfg.min_power);
    end
    pw_new = rgps_pkg::LVL_W'(pw_clamp);
  end

  // Stepped gain, clamped high first then low
  always_comb begin
    g_min   = $signed({2'b0, cfg.min_gain_index});
    g_max   = $signed({2'b0, cfg.max_gain_index});
    g_up    = $signed({2'b0, cur_gain}) + GW'(rgps_pkg::GAIN_STEP);
    g_dn    = $signed({2'b0, cur_gain}) - GW'(rgps_pkg::GAIN_STEP);
    g_sel   = too_high ? g_dn : g_up;
    g_clamp = g_sel;
    if (g_clamp > g_max) begin
      g_clamp = g_max;
    end
    if (g_clamp < g_min) begin
      g_clamp = g_min;
    end
    gn_new = g_clamp[rgps_pkg::GAIN_W-1:0];
  end

  // Pick the outcome
  always_comb begin
    res_power  = cur_power;
    res_gain   = cur_gain;
    res_status = rgps_pkg::STAT_ADJUSTING;
    wr_en      = 1'b0;
    wr_done    = cur_done;
    if (!ch_ok) begin
      res_power  = '0;
      res_gain   = '0;
      res_status = rgps_pkg::STAT_DONE;
    end else if (action == rgps_pkg::ACT_INIT) begin
      res_power = cfg.start_power;
      res_gain  = cfg.start_gain_index;
      wr_en     = 1'b1;
      wr_done   = 1'b0;
    end else begin
      wr_en = 1'b1;
      if (cur_done) begin
        res_status = rgps_pkg::STAT_DONE;
      end else if (in_win) begin
        res_status = rgps_pkg::STAT_CONVERGED;
        wr_done    = 1'b1;
      end else if (too_high) begin
        if (cur_power == cfg.min_power) begin
          if (cur_gain == cfg.min_gain_index) begin
            res_status = rgps_pkg::STAT_GAIN_HIGH;
          end else begin
            res_gain  = gn_new;
            res_power = mid;
          end
        end else begin
          res_power = pw_new;
        end
      end else begin
        if (cur_power == cfg.max_power) begin
          if (cur_gain == cfg.max_gain_index) begin
            res_status = rgps_pkg::STAT_GAIN_LOW;
          end else begin
            res_gain  = gn_new;
            res_power = mid;
          end
        end else begin
          res_power = pw_new;
        end
      end
    end
  end

endmodule

/* rtl/core/rx_gain_power_search_step_unit.sv */
// ----------------------------------------------------------------------------
// rx_gain_power_search_step_unit
// Per-channel receiver gain / source power search, one step per item.
// ----------------------------------------------------------------------------
// An item is accepted and its channel entry is read from the state memory
// at one edge; once the output register can load, the step result is
// written back and loaded into the output register. in_stall is high in the
// read state that follows each accepted beat, and stays high while a
// finished result cannot move because the output register still holds an
// earlier beat that the consumer stalls. A new beat is taken while a result
// waits on the output. There is no clearing pass after reset: power and gain
// of a channel are defined once an init beat has addressed it, and done
// marks start cleared.
module rx_gain_power_search_step_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration
  input  logic                                 cfg_we,
  input  logic [rgps_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rgps_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_action,
  input  logic [rgps_pkg::CH_W-1:0]            in_channel,
  input  logic signed [rgps_pkg::LVL_W-1:0]    in_rssi,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [rgps_pkg::CH_W-1:0]            out_channel_out,
  output logic signed [rgps_pkg::LVL_W-1:0]    out_power_out,
  output logic [rgps_pkg::GAIN_W-1:0]          out_gain_out,
  output logic [rgps_pkg::STAT_W-1:0]          out_status
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RD   = 1'b1;

  rgps_pkg::rgps_cfg_t cfg;
  rgps_pkg::rgps_wr_t  wr;

  logic state_r, state_nxt;
  logic in_fire, finish;

  logic                              act_r;
  logic [rgps_pkg::CH_W-1:0]         ch_r;
  logic signed [rgps_pkg::LVL_W-1:0] rssi_r;

  logic signed [rgps_pkg::LVL_W-1:0] rd_power, res_power;
  logic [rgps_pkg::GAIN_W-1:0]       rd_gain, res_gain;
  logic                              rd_done, wr_en, wr_done;
  logic [rgps_pkg::STAT_W-1:0]       res_status;

  logic                              out_valid_r;
  logic [rgps_pkg::CH_W-1:0]         out_ch_r;
  logic signed [rgps_pkg::LVL_W-1:0] out_power_r;
  logic [rgps_pkg::GAIN_W-1:0]       out_gain_r;
  logic [rgps_pkg::STAT_W-1:0]       out_status_r;

  rgps_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Accept only when no item is in flight; finish when the output can load
  assign in_stall = (state_r != ST_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign finish   = (state_r == ST_RD) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_fire) state_nxt = ST_RD;
      ST_RD:   if (finish)  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Capture the input beat
  always_ff @(posedge clk) begin
    if (in_fire) begin
      act_r  <= in_action;
      ch_r   <= in_channel;
      rssi_r <= in_rssi;
    end
  end

  rgps_chan_mem u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_fire),
    .rd_addr  (rgps_pkg::ch_addr(in_channel)),
    .wr       (wr),
    .rd_power (rd_power),
    .rd_gain  (rd_gain),
    .rd_done  (rd_done)
  );

  rgps_step u_step (
    .cfg        (cfg),
    .action     (act_r),
    .ch_ok      (rgps_pkg::ch_exists(ch_r)),
    .rssi       (rssi_r),
    .cur_power  (rd_power),
    .cur_gain   (rd_gain),
    .cur_done   (rd_done),
    .res_power  (res_power),
    .res_gain   (res_gain),
    .res_status (res_status),
    .wr_en      (wr_en),
    .wr_done    (wr_done)
  );

  // Write back the stepped entry
  always_comb begin
    wr.en    = finish && wr_en;
    wr.addr  = rgps_pkg::ch_addr(ch_r);
    wr.power = res_power;
    wr.gain  = res_gain;
    wr.done  = wr_done;
  end

  // Output register: load on finish, drop when the beat is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_ch_r     <= ch_r;
      out_power_r  <= res_power;
      out_gain_r   <= res_gain;
      out_status_r <= res_status;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_channel_out = out_ch_r;
  assign out_power_out   = out_power_r;
  assign out_gain_out    = out_gain_r;
  assign out_status      = out_status_r;

`include "assert_macros.svh"

  // An accepted beat always moves the sequencer into the read cycle
  `ASSERT_CLK(a_fire_to_rd, in_fire |=> (state_r == ST_RD))
  // Table written only in the cycle after its read, or later if stalled
  `ASSERT_CLK(a_wr_in_rd, wr.en |-> (state_r == ST_RD) && $past(in_fire || state_r == ST_RD))
  // A read and a write of the table never share a cycle
  `ASSERT_CLK(a_no_rd_wr, !(in_fire && wr.en))
  // A finished step shows up on the output and frees the sequencer
  `ASSERT_CLK(a_finish_out, finish |=> out_valid && (state_r == ST_IDLE))

endmodule
